// ===== design/trb_rpm_pkg.sv =====
// ----------------------------------------------------------------------------
// trb_rpm_pkg
// shared types, codes and constants of the trb ring producer manager
// ----------------------------------------------------------------------------
package trb_rpm_pkg;

  localparam int DEF_MAX_ENTRIES  = 256;
  localparam int ENTRY_BYTES_LOG2 = 4;
  localparam logic [31:0] LINK_CTRL_BASE = 32'h0000_1802;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W  = 192;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 240;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RING_BASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_ENTRIES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCER_MODE = 2'd2;

  typedef enum logic [2:0] {
    KIND_INIT    = 3'd0,
    KIND_ENQUEUE = 3'd1,
    KIND_RECLAIM = 3'd2,
    KIND_ABANDON = 3'd3,
    KIND_QUERY   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_EXEC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic norm;
    logic exec;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

// ===== design/trb_rpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// trb_rpm_ctrl
// sequencer: steps one operation through normalize, execute and finish
// ----------------------------------------------------------------------------
module trb_rpm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  trb_rpm_pkg::status_t st,
  output trb_rpm_pkg::cmd_t    cmd
);
  import trb_rpm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd.norm  = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the result
        if (!st.out_full) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/trb_rpm_dp.sv =====
// ----------------------------------------------------------------------------
// trb_rpm_dp
// datapath: config registers, ring indices, cycle bit and result register
// ----------------------------------------------------------------------------
module trb_rpm_dp #(
  parameter int MAX_ENTRIES = trb_rpm_pkg::DEF_MAX_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  trb_rpm_pkg::cmd_t                   cmd,
  output trb_rpm_pkg::status_t                st,
  input  logic                                cfg_valid,
  input  logic [trb_rpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trb_rpm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [trb_rpm_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [trb_rpm_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [trb_rpm_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import trb_rpm_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int N_W   = $clog2(MAX_ENTRIES + 1);
  localparam int SAT_W = (N_W > 9) ? N_W : 9;

  // config
  logic [63:0] base_r;
  logic [8:0]  entries_r;
  logic        prod_r;

  // ring state
  logic [IDX_W-1:0] enq_r, enq_nxt;
  logic [IDX_W-1:0] deq_r, deq_nxt;
  logic             cyc_r, cyc_nxt;

  // latched operation
  logic [2:0]  kind_r;
  logic [63:0] par_r;
  logic [31:0] stat_r;
  logic [31:0] ctrl_r;
  logic [63:0] caddr_r;

  // reclaim address check
  logic             rc_ok_r;
  logic [IDX_W-1:0] rc_idx_r;

  // pending result fields
  logic        acc_r, acc_nxt;
  logic        wv_r, wv_nxt;
  logic [63:0] wa_r, wa_nxt;
  logic [63:0] wp_r, wp_nxt;
  logic [31:0] ws_r, ws_nxt;
  logic [31:0] wc_r, wc_nxt;
  logic        arm_r, arm_nxt;
  logic [31:0] lc_r, lc_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // effective ring geometry
  logic [SAT_W-1:0] ent_ext;
  logic [SAT_W-1:0] ent_sat;
  logic [N_W-1:0]   n_eff;
  logic [N_W-1:0]   slots_n;
  logic [IDX_W-1:0] slots;
  logic [N_W-1:0]   limit;

  function automatic logic [IDX_W-1:0] fwd_dist(input logic [IDX_W-1:0] from,
                                                input logic [IDX_W-1:0] to,
                                                input logic [IDX_W-1:0] sl);
    logic [N_W-1:0] s;
    begin
      if (to >= from) s = N_W'(to) - N_W'(from);
      else            s = N_W'(to) + N_W'(sl) - N_W'(from);
      fwd_dist = s[IDX_W-1:0];
    end
  endfunction

  always_comb begin
    ent_ext = SAT_W'(entries_r);
    ent_sat = ent_ext;
    if (ent_ext < SAT_W'(4))           ent_sat = SAT_W'(4);
    if (ent_ext > SAT_W'(MAX_ENTRIES)) ent_sat = SAT_W'(MAX_ENTRIES);
    n_eff   = ent_sat[N_W-1:0];
    slots_n = n_eff - N_W'(1);
    slots   = slots_n[IDX_W-1:0];
    limit   = prod_r ? slots_n : n_eff;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      entries_r <= 9'd256;
      prod_r    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RING_BASE:     base_r    <= cfg_data;
        REG_RING_ENTRIES:  entries_r <= cfg_data[8:0];
        REG_PRODUCER_MODE: prod_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= in_tuser;
      par_r   <= in_tdata[63:0];
      stat_r  <= in_tdata[95:64];
      ctrl_r  <= in_tdata[127:96];
      caddr_r <= in_tdata[191:128];
    end
  end

  // reclaim offset check
  logic [64:0] off_ext;
  logic [63:0] off;
  logic        off_borrow;
  logic        rc_ok_nxt;

  always_comb begin
    off_ext    = {1'b0, caddr_r} - {1'b0, base_r};
    off        = off_ext[63:0];
    off_borrow = off_ext[64];
    rc_ok_nxt  = prod_r && !off_borrow && (off[3:0] == 4'd0) &&
                 (off[63:ENTRY_BYTES_LOG2+IDX_W] == '0) &&
                 (off[ENTRY_BYTES_LOG2 +: IDX_W] < slots);
  end

  always_ff @(posedge clk) begin
    if (cmd.norm) begin
      rc_ok_r  <= rc_ok_nxt;
      rc_idx_r <= off[ENTRY_BYTES_LOG2 +: IDX_W];
    end
  end

  // operation execute
  logic [IDX_W-1:0] queued;
  logic [IDX_W-1:0] reach;
  logic [N_W-1:0]   enq_inc;
  logic [N_W-1:0]   rc_inc;
  logic [IDX_W-1:0] addr_idx;
  logic [63:0]      addr_sum;
  logic             full;

  always_comb begin
    queued   = fwd_dist(deq_r, enq_r, slots);
    reach    = fwd_dist(deq_r, rc_idx_r, slots);
    full     = prod_r && (queued == (slots - IDX_W'(1)));
    enq_inc  = N_W'(enq_r) + N_W'(1);
    rc_inc   = N_W'(rc_idx_r) + N_W'(1);
    addr_idx = (kind_t'(kind_r) == KIND_INIT) ? slots : enq_r;
    addr_sum = base_r + (64'(addr_idx) << ENTRY_BYTES_LOG2);
  end

  always_comb begin
    enq_nxt = enq_r;
    deq_nxt = deq_r;
    cyc_nxt = cyc_r;
    acc_nxt = 1'b1;
    wv_nxt  = 1'b0;
    wa_nxt  = '0;
    wp_nxt  = '0;
    ws_nxt  = '0;
    wc_nxt  = '0;
    arm_nxt = 1'b0;
    lc_nxt  = '0;
    if (cmd.norm) begin
      // indices left beyond a shrunk ring restart at slot zero
      if (N_W'(enq_r) >= limit) enq_nxt = '0;
      if (N_W'(deq_r) >= limit) deq_nxt = '0;
    end else if (cmd.exec) begin
      case (kind_t'(kind_r))
        KIND_INIT: begin
          enq_nxt = '0;
          deq_nxt = '0;
          cyc_nxt = 1'b1;
          if (prod_r) begin
            wv_nxt = 1'b1;
            wa_nxt = addr_sum;
            wp_nxt = base_r;
            wc_nxt = LINK_CTRL_BASE;
          end
        end
        KIND_ENQUEUE: begin
          if (full) begin
            acc_nxt = 1'b0;
          end else begin
            wv_nxt  = 1'b1;
            wa_nxt  = addr_sum;
            wp_nxt  = par_r;
            ws_nxt  = stat_r;
            wc_nxt  = {ctrl_r[31:1], cyc_r};
            enq_nxt = enq_inc[IDX_W-1:0];
            if (prod_r && (enq_inc >= slots_n)) begin
              arm_nxt = 1'b1;
              lc_nxt  = LINK_CTRL_BASE | {31'd0, cyc_r};
              cyc_nxt = ~cyc_r;
              enq_nxt = '0;
            end else if (!prod_r && (enq_inc >= n_eff)) begin
              cyc_nxt = ~cyc_r;
              enq_nxt = '0;
            end
          end
        end
        KIND_RECLAIM: begin
          if (rc_ok_r && (reach < queued)) begin
            if (rc_inc >= slots_n) deq_nxt = '0;
            else                   deq_nxt = rc_inc[IDX_W-1:0];
          end
        end
        KIND_ABANDON: begin
          if (prod_r) deq_nxt = enq_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enq_r <= '0;
      deq_r <= '0;
      cyc_r <= 1'b1;
    end else begin
      enq_r <= enq_nxt;
      deq_r <= deq_nxt;
      cyc_r <= cyc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_r <= acc_nxt;
      wv_r  <= wv_nxt;
      wa_r  <= wa_nxt;
      wp_r  <= wp_nxt;
      ws_r  <= ws_nxt;
      wc_r  <= wc_nxt;
      arm_r <= arm_nxt;
      lc_r  <= lc_nxt;
    end
  end

  // finish: free space from the updated indices, then load the result
  logic [IDX_W-1:0] free_now;
  logic [IDX_W+7:0] free_ext;
  logic [7:0]       free8;

  always_comb begin
    free_now = slots - IDX_W'(1) - fwd_dist(deq_r, enq_r, slots);
    free_ext = {8'd0, free_now};
    free8    = prod_r ? free_ext[7:0] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data_r <= {4'd0, cyc_r, free8, lc_r, arm_r, wc_r, ws_r, wp_r, wa_r, wv_r, acc_r};
    end
  end

  assign st.out_full = out_valid_r && !out_tready;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;

endmodule

// ===== design/trb_ring_producer_manager.sv =====
// ----------------------------------------------------------------------------
// trb_ring_producer_manager
// producer-side index and cycle bit manager for a ring of 16-byte entries
// ----------------------------------------------------------------------------
// Each input beat is one ring operation selected by in_tuser (initialise,
// enqueue, reclaim, abandon, query; other codes act as query) and produces
// exactly one result beat. An operation steps through the sequencer states
// (accept in idle, index normalize plus reclaim address check, execute,
// free-space finish), and the result register loads at the finish step. The
// sequencer steps the one shared datapath; a new beat is taken as soon as the
// sequencer is back in idle, even while the previous result still waits on
// out_tready. The finish step stalls while the result register is full.
// Configuration writes are always ready and are meant to be made while idle.
// ----------------------------------------------------------------------------
module trb_ring_producer_manager #(
  parameter int MAX_ENTRIES = trb_rpm_pkg::DEF_MAX_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [trb_rpm_pkg::CFG_IDX_W-1:0]   cfg_index,  // 0 base, 1 entries, 2 mode
  input  logic [trb_rpm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // operation stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // entry_parameter[63:0], entry_status[95:64], entry_control[127:96],
  // completed_address[191:128]
  input  logic [trb_rpm_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind[2:0]
  input  logic [trb_rpm_pkg::IN_USER_W-1:0]   in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // accepted[0], write_valid[1], write_address[65:2], write_parameter[129:66],
  // write_status[161:130], write_control[193:162], link_armed[194],
  // link_word[226:195], free_slots[234:227], cycle_now[235], zero pad
  output logic [trb_rpm_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import trb_rpm_pkg::*;

  cmd_t    cmd;
  status_t st;

  // config registers are plain flops, never busy
  assign cfg_ready = 1'b1;

  trb_rpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  trb_rpm_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
